// ----- hdl/svm_pkg.sv -----
// Shared types, constants and helpers for the sample voice mixer.
// No dependencies; imported by sample_voice_mixer_top.
package svm_pkg;

    localparam int VOICES    = 16;
    localparam int MEM_WORDS = 16384;

    localparam int MADDR_W = $clog2(MEM_WORDS);
    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCNT_W  = $clog2(VOICES + 1);
    localparam int CNT_W   = (VCNT_W > 5) ? VCNT_W : 5;
    localparam int ACC_W   = 17 + VCNT_W;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [14:0] MAX_LEN = 15'd16384;
    localparam logic [4:0]  CNT_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]         kind;
        logic [13:0]        address;
        logic [14:0]        length;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
        logic [4:0]         active_voices;
        logic               start_dropped;
    } t_out_req;

    typedef struct packed {
        logic [13:0] base;
        logic [14:0] length;
        logic [14:0] position;
    } t_voice;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    function automatic logic [MADDR_W-1:0] mem_index(input logic [15:0] a);
        logic [MADDR_W+15:0] wide;
        wide = {{MADDR_W{1'b0}}, a};
        return wide[MADDR_W-1:0];
    endfunction

endpackage

// ----- hdl/sample_voice_mixer_top.sv -----
// Stereo sample mixer: sample memory, voice table and tick walker.
// Depends on svm_pkg.
// Write and start requests are handled in idle, which stays ready for the next request.
// After a tick is accepted the walker reads the voice table once per voice, drains the
// voice/sample memory pipeline, passes to the flush state and loads the output register
// (waiting while it is full); the next request is accepted once it is back in idle.
// Reset clears all voices to inactive and the dropped flag; sample memory is not cleared
// and reads undefined until written.
module sample_voice_mixer_top import svm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    logic [31:0] r_smem [MEM_WORDS];
    t_voice      r_vmem [VOICES];

    t_state r_state, n_state;
    logic [VOICES-1:0]       r_active;
    logic                    r_dropped;
    logic [VCNT_W-1:0]       r_issue;
    logic                    r_v1_valid, r_v2_valid;
    logic [VIDX_W-1:0]       r_v1_idx;
    t_voice                  r_vrd;
    logic [31:0]             r_srd;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;
    logic [CNT_W-1:0]        r_count;
    logic                    r_out_valid;
    t_out_req                r_out;

    logic              in_acc;
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              issuing;
    logic [14:0]       new_pos;
    logic [15:0]       rd_sum;
    logic              out_load;
    logic [14:0]       start_len;
    logic              do_start;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(i);
            end
        end
    end

    assign start_len = (i_in_req.length > MAX_LEN) ? MAX_LEN : i_in_req.length;
    assign do_start  = in_acc && (i_in_req.kind == KIND_START) && (i_in_req.length != 15'd0);
    assign issuing   = (r_state == S_RUN) && (r_issue != VCNT_W'(VOICES));
    assign new_pos   = r_vrd.position + 15'd1;
    assign rd_sum    = {2'b00, r_vrd.base} + {1'b0, r_vrd.position};
    assign out_load  = (r_state == S_FLUSH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_req.kind == KIND_TICK) n_state = S_RUN;
            end
            S_RUN: begin
                if (!issuing && !r_v1_valid && !r_v2_valid) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sample memory: write in idle, read during the walk
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.kind == KIND_WRITE) begin
            r_smem[mem_index({2'b00, i_in_req.address})] <=
                {i_in_req.sample_right, i_in_req.sample_left};
        end
        r_srd <= r_smem[mem_index(rd_sum)];
    end

    // voice table: start write or position write-back
    always_ff @(posedge i_clk) begin
        if (do_start && free_found) begin
            r_vmem[free_idx] <= '{base: i_in_req.address, length: start_len, position: 15'd0};
        end else if (r_v1_valid) begin
            r_vmem[r_v1_idx] <= '{base: r_vrd.base, length: r_vrd.length, position: new_pos};
        end
        r_vrd <= r_vmem[r_issue[VIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_dropped   <= 1'b0;
            r_issue     <= '0;
            r_v1_valid  <= 1'b0;
            r_v2_valid  <= 1'b0;
            r_v1_idx    <= '0;
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (do_start) begin
                if (free_found) begin
                    r_active[free_idx] <= 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            if (in_acc && i_in_req.kind == KIND_TICK) begin
                r_issue <= '0;
                r_acc_l <= '0;
                r_acc_r <= '0;
                r_count <= '0;
            end else if (issuing) begin
                r_issue <= r_issue + VCNT_W'(1);
            end

            r_v1_valid <= issuing && r_active[r_issue[VIDX_W-1:0]];
            r_v1_idx   <= r_issue[VIDX_W-1:0];

            // advance the voice and free it once it has played every sample
            if (r_v1_valid && (new_pos >= r_vrd.length)) begin
                r_active[r_v1_idx] <= 1'b0;
            end
            r_v2_valid <= r_v1_valid;

            if (r_v2_valid) begin
                r_acc_l <= r_acc_l + ACC_W'($signed(r_srd[15:0]));
                r_acc_r <= r_acc_r + ACC_W'($signed(r_srd[31:16]));
                r_count <= r_count + CNT_W'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_dropped   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload: saturate and hold
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_acc_l > ACC_W'(32767)) begin
                r_out.mix_left <= 16'sd32767;
            end else if (r_acc_l < -ACC_W'(32768)) begin
                r_out.mix_left <= -16'sd32768;
            end else begin
                r_out.mix_left <= r_acc_l[15:0];
            end
            if (r_acc_r > ACC_W'(32767)) begin
                r_out.mix_right <= 16'sd32767;
            end else if (r_acc_r < -ACC_W'(32768)) begin
                r_out.mix_right <= -16'sd32768;
            end else begin
                r_out.mix_right <= r_acc_r[15:0];
            end
            r_out.active_voices <= (r_count > CNT_W'(CNT_MAX)) ? CNT_MAX : r_count[4:0];
            r_out.start_dropped <= r_dropped;
        end
    end

endmodule
